// File: design/tacc_pkg.sv
// ---------------------------------------------------------------------------
// tacc_pkg
// Shared types and constants for the tilt accumulator with centering
// ---------------------------------------------------------------------------
package tacc_pkg;

  localparam int unsigned TiltW   = 16;
  localparam int unsigned SensW   = 16;
  localparam int unsigned MaxW    = 15;
  localparam int unsigned SpeedW  = 16;
  localparam int unsigned ElapsW  = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    KIND_DELTA  = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_ACTIVE = 2'd2,
    KIND_RESET  = 2'd3
  } kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SENS  = 2'd0,
    REG_MAX   = 2'd1,
    REG_SPEED = 2'd2,
    REG_NONE  = 2'd3
  } cfg_idx_t;

endpackage

// File: design/tacc_if.sv
// ---------------------------------------------------------------------------
// tacc_if
// Request channels: input items, result items and register writes
// ---------------------------------------------------------------------------
interface tacc_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        kind;
  logic signed [tacc_pkg::TiltW-1:0] delta_x;
  logic signed [tacc_pkg::TiltW-1:0] delta_y;
  logic [tacc_pkg::ElapsW-1:0]       elapsed;
  logic                              enable;
  modport source (output valid, kind, delta_x, delta_y, elapsed, enable, input ready);
  modport sink   (input valid, kind, delta_x, delta_y, elapsed, enable, output ready);
endinterface

interface tacc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [tacc_pkg::TiltW-1:0] tilt_x;
  logic signed [tacc_pkg::TiltW-1:0] tilt_y;
  modport source (output valid, tilt_x, tilt_y, input ready);
  modport sink   (input valid, tilt_x, tilt_y, output ready);
endinterface

interface tacc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tacc_pkg::CfgIdxW-1:0]       index;
  logic [tacc_pkg::SensW-1:0]         data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/tilt_accumulator_with_centering_unit.sv
// ---------------------------------------------------------------------------
// tilt_accumulator_with_centering_unit
// Two-axis tilt accumulator with bit-serial gain, square root and pull-back
// ---------------------------------------------------------------------------
//  channel  | dir | payload
//  in_ch    | in  | kind, delta_x, delta_y, elapsed, enable
//  out_ch   | out | tilt_x, tilt_y
//  cfg_ch   | in  | index, data
//
//  delta items: one gain bit a cycle
//  tick items: speed mult, squares, sqrt, compare, then multiply and divide per axis;
//  the multiply and divide are skipped when the tilt snaps to zero
//  set-active, reset and ignored items finish in S_IDLE; one item in flight
//  result held in an output register; a second result waits and holds in_ch.ready low
//  rst is synchronous: tilt zero, inactive, registers at 1.0
module tilt_accumulator_with_centering_unit #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic   clk,
  input  logic   rst,
  tacc_in_if.sink    in_ch,
  tacc_out_if.source out_ch,
  tacc_cfg_if.sink   cfg_ch
);
  import tacc_pkg::*;

  localparam int unsigned PW = 34;  // wide enough for products and squares
  localparam logic [SensW-1:0] ONE = SensW'(1) << FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_MULY, S_SPD, S_SQ, S_SQY, S_SQRT, S_CMP, S_DIV, S_DIVY, S_DONE
  } state_t;

  state_t state;
  logic [SensW-1:0]  sensitivity;
  logic [MaxW-1:0]   max_tilt;
  logic [SpeedW-1:0] centering_speed;
  logic signed [TiltW-1:0] tx, ty;
  logic              active;
  logic              pend;
  logic [1:0]        kind;
  logic signed [TiltW-1:0] dx, dy;
  logic [ElapsW-1:0] elaps;
  // shared bit-serial multiply / divide datapath
  logic [PW-1:0]     acc, mcand, sq;
  logic [16:0]       mplier;
  logic [5:0]        cnt;
  logic [16:0]       step;
  logic [PW-1:0]     mag;
  logic [PW-1:0]     rem;
  logic [33:0]       bitv;
  logic              out_valid;
  logic signed [TiltW-1:0] out_x, out_y;

  assign in_ch.ready   = (state == S_IDLE) && !pend;
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid;
  assign out_ch.tilt_x = out_x;
  assign out_ch.tilt_y = out_y;

  function automatic logic [TiltW-1:0] absv(input logic signed [TiltW-1:0] a);
    absv = a[TiltW-1] ? TiltW'(-a) : a;
  endfunction

  function automatic logic signed [TiltW-1:0] clampv(input logic signed [PW:0] v,
                                                    input logic [MaxW-1:0] m);
    logic signed [PW:0] mm;
    mm = (PW+1)'(m);
    if (v > mm) clampv = TiltW'(mm);
    else if (v < -mm) clampv = TiltW'(-mm);
    else clampv = TiltW'(v);
  endfunction

  logic signed [PW:0] sum_v;
  logic [PW-1:0]      trial;
  logic [PW-1:0]      rem_sh;
  logic signed [TiltW-1:0] cur_a;

  always_comb begin
    cur_a  = (state == S_MULY || state == S_SQY || state == S_DIVY) ? ty : tx;
    sum_v  = (PW+1)'(signed'(cur_a)) + (cur_a == cur_a ? (PW+1)'(0) : (PW+1)'(0));
    trial  = mag + bitv;
    rem_sh = {rem[PW-2:0], acc[PW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sensitivity <= ONE;
      max_tilt <= MaxW'(ONE);
      centering_speed <= ONE;
      tx <= '0;
      ty <= '0;
      active <= 1'b0;
      pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_idx_t'(cfg_ch.index))
          REG_SENS:  sensitivity <= cfg_ch.data;
          REG_MAX:   max_tilt <= cfg_ch.data[MaxW-1:0];
          REG_SPEED: centering_speed <= cfg_ch.data;
          default:   ;
        endcase
      end
      if (pend && !(out_valid && !out_ch.ready)) begin
        out_valid <= 1'b1;
        out_x <= tx;
        out_y <= ty;
        pend <= 1'b0;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            kind  <= in_ch.kind;
            dx    <= in_ch.delta_x;
            dy    <= in_ch.delta_y;
            elaps <= in_ch.elapsed;
            case (kind_t'(in_ch.kind))
              KIND_DELTA: begin
                if (active) begin
                  acc <= '0; mcand <= PW'(absv(in_ch.delta_x));
                  mplier <= 17'(sensitivity); cnt <= 6'd17; state <= S_MUL;
                end
              end
              KIND_TICK: begin
                if (active && (tx != 0 || ty != 0)) begin
                  acc <= '0; mcand <= PW'(centering_speed);
                  mplier <= 17'(in_ch.elapsed); cnt <= 6'd17; state <= S_SPD;
                end
              end
              KIND_ACTIVE: begin
                active <= in_ch.enable;
                if (!in_ch.enable) begin
                  tx <= '0; ty <= '0; pend <= 1'b1;
                end
              end
              default: begin
                tx <= '0; ty <= '0; pend <= 1'b1;
              end
            endcase
          end
        end
        // shift-and-add multiply, one multiplier bit a cycle
        S_MUL, S_MULY, S_SPD, S_SQ, S_SQY: begin
          if (cnt != 0) begin
            if (mplier[0]) acc <= acc + mcand;
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
            cnt    <= cnt - 6'd1;
          end else begin
            case (state)
              S_MUL: begin
                tx <= clampv((PW+1)'(tx) + (dx[TiltW-1] ? -((PW+1)'(acc >> FRAC_BITS))
                                                        :  (PW+1)'(acc >> FRAC_BITS)),
                             max_tilt);
                acc <= '0; mcand <= PW'(absv(dy));
                mplier <= 17'(sensitivity); cnt <= 6'd17; state <= S_MULY;
              end
              S_MULY: begin
                ty <= clampv((PW+1)'(ty) + (dy[TiltW-1] ? -((PW+1)'(acc >> FRAC_BITS))
                                                        :  (PW+1)'(acc >> FRAC_BITS)),
                             max_tilt);
                pend <= 1'b1; state <= S_IDLE;
              end
              S_SPD: begin
                step <= 17'(acc >> 16);
                acc <= '0; mcand <= PW'(absv(tx));
                mplier <= 17'(absv(tx)); cnt <= 6'd17; state <= S_SQ;
              end
              S_SQ: begin
                sq <= acc;
                acc <= '0; mcand <= PW'(absv(ty));
                mplier <= 17'(absv(ty)); cnt <= 6'd17; state <= S_SQY;
              end
              default: begin
                rem <= sq + acc; mag <= '0; bitv <= 34'd1 << 32; state <= S_SQRT;
              end
            endcase
          end
        end
        // digit-by-digit square root, two radicand bits a cycle
        S_SQRT: begin
          if (bitv == 0) state <= S_CMP;
          else begin
            if (rem >= trial) begin
              rem <= rem - trial;
              mag <= (mag >> 1) + bitv;
            end else mag <= mag >> 1;
            bitv <= bitv >> 2;
          end
        end
        S_CMP: begin
          if (PW'(step) >= mag) begin
            tx <= '0; ty <= '0; pend <= 1'b1; state <= S_IDLE;
          end else begin
            acc <= '0; mcand <= PW'(absv(tx)); mplier <= step;
            cnt <= 6'd17; state <= S_DIV; bitv <= '0;
          end
        end
        // multiply |axis|*step, then restoring divide by mag, one bit a cycle
        S_DIV, S_DIVY: begin
          if (bitv[0] == 1'b0) begin
            if (cnt != 0) begin
              if (mplier[0]) acc <= acc + mcand;
              mcand <= mcand << 1; mplier <= mplier >> 1; cnt <= cnt - 6'd1;
            end else begin
              bitv[0] <= 1'b1; rem <= '0; cnt <= 6'(PW);
            end
          end else if (cnt != 0) begin
            acc <= {acc[PW-2:0], (rem_sh >= mag)};
            rem <= (rem_sh >= mag) ? rem_sh - mag : rem_sh;
            cnt <= cnt - 6'd1;
          end else if (state == S_DIV) begin
            tx <= tx[TiltW-1] ? tx + TiltW'(acc) : tx - TiltW'(acc);
            acc <= '0; mcand <= PW'(absv(ty)); mplier <= step;
            cnt <= 6'd17; bitv <= '0; state <= S_DIVY;
          end else begin
            ty <= ty[TiltW-1] ? ty + TiltW'(acc) : ty - TiltW'(acc);
            pend <= 1'b1; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = ^{sum_v, kind, elaps};
endmodule

// File: design/tacc_checker.sv
// ---------------------------------------------------------------------------
// tacc_checker
// Port-level checks for the tilt accumulator
// ---------------------------------------------------------------------------
module tacc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] tilt_x
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tilt_x))
    else $error("result dropped or changed while stalled");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result too soon after request");
endmodule

bind tilt_accumulator_with_centering_unit tacc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .tilt_x(out_ch.tilt_x)
);

// File: tb/tb_tilt_accumulator_with_centering_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_tilt_accumulator_with_centering_unit
// Drives delta, tick, set-active and reset requests with random gaps and
// result stalls, predicts each tilt update and checks it field by field
// ---------------------------------------------------------------------------
module tb_tilt_accumulator_with_centering_unit;
  import tacc_pkg::*;

  localparam int FracBits = 8;
  localparam int DrainCycles = 200;

  class tilt_scoreboard;
    int unsigned gain;
    int unsigned clamp_mag;
    int unsigned pull_speed;
    int signed   pos_x;
    int signed   pos_y;
    bit          engaged;
    logic signed [15:0] pending_x[$];
    logic signed [15:0] pending_y[$];
    int          errors;
    int          checked;

    function void clear();
      gain = 256; clamp_mag = 256; pull_speed = 256;
      pos_x = 0; pos_y = 0; engaged = 0; errors = 0; checked = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] val);
      case (idx)
        REG_SENS:  gain = val;
        REG_MAX:   clamp_mag = val[14:0];
        REG_SPEED: pull_speed = val;
        default: ;
      endcase
    endfunction

    function longint scaled(int signed d);
      longint mag;
      longint p;
      mag = (d < 0) ? -longint'(d) : longint'(d);
      p = (mag * gain) >>> FracBits;
      return (d < 0) ? -p : p;
    endfunction

    function int signed clamped(longint v);
      if (v > longint'(clamp_mag)) return clamp_mag;
      if (v < -longint'(clamp_mag)) return -int'(clamp_mag);
      return int'(v);
    endfunction

    function longint root_floor(longint v);
      longint r;
      longint b;
      r = 0;
      b = longint'(1) <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >>> 1) + b;
        end else begin
          r = r >>> 1;
        end
        b = b >>> 2;
      end
      return r;
    endfunction

    function int signed pulled(int signed a, longint stp, longint mag);
      longint ua;
      longint d;
      ua = (a < 0) ? -longint'(a) : longint'(a);
      d = (ua * stp) / mag;
      return (a < 0) ? int'(a + d) : int'(a - d);
    endfunction

    function void note_request(kind_t k, logic signed [15:0] dx, logic signed [15:0] dy,
                               logic [15:0] el, logic en);
      longint stp;
      longint mag;
      case (k)
        KIND_DELTA: begin
          if (!engaged) return;
          pos_x = clamped(longint'(pos_x) + scaled(int'(dx)));
          pos_y = clamped(longint'(pos_y) + scaled(int'(dy)));
        end
        KIND_TICK: begin
          if (!engaged || (pos_x == 0 && pos_y == 0)) return;
          stp = (longint'(pull_speed) * longint'(el)) >>> 16;
          mag = root_floor(longint'(pos_x) * pos_x + longint'(pos_y) * pos_y);
          if (stp >= mag) begin
            pos_x = 0; pos_y = 0;
          end else begin
            pos_x = pulled(pos_x, stp, mag);
            pos_y = pulled(pos_y, stp, mag);
          end
        end
        KIND_ACTIVE: begin
          engaged = en;
          if (en) return;
          pos_x = 0; pos_y = 0;
        end
        default: begin
          pos_x = 0; pos_y = 0;
        end
      endcase
      pending_x.push_back(pos_x[15:0]);
      pending_y.push_back(pos_y[15:0]);
    endfunction

    function void check_result(logic signed [15:0] tx, logic signed [15:0] ty);
      logic signed [15:0] ex;
      logic signed [15:0] ey;
      checked++;
      if (pending_x.size() == 0) begin
        $error("unexpected result tilt_x=%0d tilt_y=%0d", tx, ty);
        errors++;
        return;
      end
      ex = pending_x.pop_front();
      ey = pending_y.pop_front();
      if (tx !== ex) begin
        $error("tilt_x expected %0d actual %0d", ex, tx);
        errors++;
      end
      if (ty !== ey) begin
        $error("tilt_y expected %0d actual %0d", ey, ty);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  always #6 clk = ~clk;

  tacc_in_if  in_ch ();
  tacc_out_if out_ch ();
  tacc_cfg_if cfg_ch ();

  tilt_accumulator_with_centering_unit #(.FRAC_BITS(FracBits)) u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  tilt_scoreboard sb = new();
  int sent;
  int stall_mode;
  int burst_left;

  // result side: stall pattern changes per phase
  initial out_ch.ready = 0;
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 0;
    else case (stall_mode)
      0: out_ch.ready <= 1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.tilt_x, out_ch.tilt_y);
  end

  task automatic send_request(kind_t k, logic signed [15:0] dx, logic signed [15:0] dy,
                              logic [15:0] el, logic en);
    if (burst_left == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid   <= 1;
    in_ch.kind    <= k;
    in_ch.delta_x <= dx;
    in_ch.delta_y <= dy;
    in_ch.elapsed <= el;
    in_ch.enable  <= en;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(k, dx, dy, el, en);
    sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 0;
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 0;
    burst_left = 0;
    while (sb.pending_x.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic random_request();
    int r;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    r = $urandom_range(0, 99);
    dx = 16'($urandom);
    dy = 16'($urandom);
    if ($urandom_range(0, 2) == 0) begin
      dx = 16'(int'($urandom_range(0, 1023)) - 512);
      dy = 16'(int'($urandom_range(0, 1023)) - 512);
    end
    if (r < 50) send_request(KIND_DELTA, dx, dy, 16'($urandom), 1'($urandom));
    else if (r < 85) send_request(KIND_TICK, 16'($urandom), 16'($urandom),
                                   16'($urandom_range(0, 1) ? $urandom_range(0, 2000)
                                                            : $urandom),
                                   1'($urandom));
    else if (r < 95) send_request(KIND_ACTIVE, 16'($urandom), 16'($urandom), 16'($urandom),
                                   ($urandom_range(0, 4) != 0));
    else send_request(KIND_RESET, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
  endtask

  initial begin
    sb.clear();
    sent = 0; stall_mode = 0; burst_left = 0;
    in_ch.valid = 0; in_ch.kind = KIND_DELTA; in_ch.delta_x = 0; in_ch.delta_y = 0;
    in_ch.elapsed = 0; in_ch.enable = 0;
    cfg_ch.valid = 0; cfg_ch.index = REG_SENS; cfg_ch.data = 0;
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: inactive items, activation, extremes, zero step, snap
    send_request(KIND_DELTA, 16'sd100, 16'sd100, 0, 0);
    send_request(KIND_TICK, 0, 0, 16'hFFFF, 0);
    send_request(KIND_ACTIVE, 0, 0, 0, 0);
    send_request(KIND_RESET, 0, 0, 0, 0);
    send_request(KIND_ACTIVE, 0, 0, 0, 1);
    send_request(KIND_TICK, 0, 0, 16'hFFFF, 0);
    send_request(KIND_DELTA, 16'sh7FFF, -16'sh8000, 0, 0);
    send_request(KIND_TICK, 0, 0, 0, 0);
    send_request(KIND_TICK, 0, 0, 16'd100, 0);
    send_request(KIND_DELTA, -16'sd1, 16'sd1, 0, 0);
    send_request(KIND_TICK, 0, 0, 16'hFFFF, 0);
    send_request(KIND_DELTA, 16'sd60, -16'sd30, 0, 0);
    send_request(KIND_TICK, 0, 0, 16'd5000, 0);
    send_request(KIND_ACTIVE, 0, 0, 0, 1);
    send_request(KIND_RESET, 0, 0, 0, 0);
    settle();

    write_reg(REG_SENS, 16'hFFFF);
    write_reg(REG_MAX, 16'h7FFF);
    write_reg(REG_SPEED, 16'hFFFF);
    send_request(KIND_DELTA, 16'sh7FFF, -16'sh8000, 0, 0);
    send_request(KIND_DELTA, -16'sh8000, 16'sh7FFF, 0, 0);
    send_request(KIND_TICK, 0, 0, 16'd1, 0);
    send_request(KIND_TICK, 0, 0, 16'hFFFF, 0);
    settle();
    // tilt beyond a lowered clamp survives until the next delta
    send_request(KIND_DELTA, 16'sd20000, -16'sd20000, 0, 0);
    settle();
    write_reg(REG_MAX, 16'd0);
    write_reg(REG_SENS, 16'd0);
    write_reg(REG_SPEED, 16'd0);
    send_request(KIND_TICK, 0, 0, 16'hFFFF, 0);
    send_request(KIND_DELTA, 16'sd5, 16'sd5, 0, 0);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      stall_mode = ph % 3;
      case (ph)
        0: begin write_reg(REG_SENS, 256); write_reg(REG_MAX, 256); write_reg(REG_SPEED, 256); end
        1: begin write_reg(REG_SENS, 16'hFFFF); write_reg(REG_MAX, 15'h7FFF); end
        7: begin write_reg(REG_SENS, 0); write_reg(REG_MAX, 0); write_reg(REG_SPEED, 0); end
        default: begin
          write_reg(REG_SENS, 16'($urandom_range(0, 2048)));
          write_reg(REG_MAX, 16'($urandom_range(0, 32767)));
          write_reg(REG_SPEED, 16'($urandom_range(0, 65535)));
        end
      endcase
      send_request(KIND_ACTIVE, 0, 0, 0, 1);
      for (int i = 0; i < 100; i++) random_request();
      settle();
    end

    $display("run covered %0d requests and %0d results over 8 register settings",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending_x.size() == 0) begin
      $display("[tilt_accumulator_with_centering_unit] OK");
    end else begin
      $display("[tilt_accumulator_with_centering_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[tilt_accumulator_with_centering_unit] ERROR");
    $finish;
  end
endmodule

// File: tilt_accumulator_with_centering_unit.f
design/tacc_pkg.sv
design/tacc_if.sv
design/tilt_accumulator_with_centering_unit.sv
design/tacc_checker.sv
tb/tb_tilt_accumulator_with_centering_unit.sv
